[design/sfcs_pkg.sv]
// sfcs_pkg: shared types, codes and command bytes of the spi flash command sequencer
// used by the request channel interface, the sequencing engine and the top level

package sfcs_pkg;

   localparam int MAX_RESULTS = 3;

   // request and event codes carried in the operation field
   typedef enum logic [2:0] {
      OP_READ_ID   = 3'd0,
      OP_READ      = 3'd1,
      OP_PROGRAM   = 3'd2,
      OP_ERASE     = 3'd3,
      OP_SPI_RX    = 3'd4,
      OP_PROG_DATA = 3'd5
   } op_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_XFER    = 3'd0,
      KIND_RELEASE = 3'd1,
      KIND_DATA    = 3'd2,
      KIND_ID      = 3'd3,
      KIND_DONE    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_WREN,
      PH_CMD,
      PH_ADDR,
      PH_IDDATA,
      PH_RDATA,
      PH_PWAIT,
      PH_PBYTE,
      PH_PLAST,
      PH_RDSR,
      PH_POLL
   } phase_type;

   localparam logic [7:0] CMD_READ_ID  = 8'h9F;
   localparam logic [7:0] CMD_READ     = 8'h03;
   localparam logic [7:0] CMD_WREN     = 8'h06;
   localparam logic [7:0] CMD_PROGRAM  = 8'h02;
   localparam logic [7:0] CMD_ERASE    = 8'hD8;
   localparam logic [7:0] CMD_RDSR     = 8'h05;
   localparam logic [7:0] DUMMY_BYTE   = 8'h00;

   typedef struct packed {
      logic [2:0]  operation;
      logic [23:0] address;
      logic [24:0] length;
      logic [7:0]  data_byte;
      logic        last_data;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic [7:0] read_byte;
      logic [7:0] vendor_id;
      logic [7:0] device_type;
      logic [7:0] capacity_code;
      logic       last;
   } rsp_item_type;

   // everything one item produces, first result in items[0]
   typedef struct packed {
      logic [1:0]                         count;
      rsp_item_type [MAX_RESULTS-1:0]     items;
   } step_out_type;

   function automatic logic [7:0] cmd_byte(input logic [1:0] req_kind);
      logic [7:0] b;
      unique case (req_kind)
         2'd0:    b = CMD_READ_ID;
         2'd1:    b = CMD_READ;
         2'd2:    b = CMD_PROGRAM;
         default: b = CMD_ERASE;
      endcase
      return b;
   endfunction

   function automatic rsp_item_type xfer_item(input logic [7:0] tx);
      rsp_item_type r;
      r = '0;
      r.kind = KIND_XFER;
      r.tx_byte = tx;
      return r;
   endfunction

   function automatic rsp_item_type kind_item(input kind_type k);
      rsp_item_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

endpackage

[design/sfcs_req_if.sv]
// sfcs_req_if: request channel of the sequencer, valid/ready plus request fields
// depends on sfcs_pkg only for the struct view of the payload

interface sfcs_req_if import sfcs_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [23:0] address;
   logic [24:0] length;
   logic [7:0]  data_byte;
   logic        last_data;
   logic [7:0]  rx_byte;

   function automatic req_item_type payload();
      req_item_type p;
      p.operation = operation;
      p.address   = address;
      p.length    = length;
      p.data_byte = data_byte;
      p.last_data = last_data;
      p.rx_byte   = rx_byte;
      return p;
   endfunction

   modport source(output valid, operation, address, length, data_byte, last_data, rx_byte,
                  input ready);
   modport sink(input valid, operation, address, length, data_byte, last_data, rx_byte,
                output ready, import payload);
endinterface

[design/sfcs_rsp_if.sv]
// sfcs_rsp_if: result channel of the sequencer, valid/ready plus result fields
// standalone, no package needed

interface sfcs_rsp_if ();
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] tx_byte;
   logic [7:0] read_byte;
   logic [7:0] vendor_id;
   logic [7:0] device_type;
   logic [7:0] capacity_code;
   logic       last;

   modport source(output valid, kind, tx_byte, read_byte, vendor_id, device_type,
                  capacity_code, last, input ready);
   modport sink(input valid, kind, tx_byte, read_byte, vendor_id, device_type,
                capacity_code, last, output ready);
endinterface

[design/spi_flash_command_sequencer.sv]
// spi_flash_command_sequencer: top level, input register, sequencing engine, result buffer
// depends on sfcs_pkg, sfcs_req_if, sfcs_rsp_if and sfcs_engine
//
// Sequences read id, read, page program and sector erase commands for a serial NOR
// flash, one SPI byte transfer at a time, advancing on each received-byte event.
// Every item on req_ch is registered, then run through the state machine; its zero to
// three results go into a small result buffer that drains on rsp_ch one per cycle while
// rsp_ch is ready. An item waits in the input register until the buffer can take its
// results, which are registered there before reaching rsp_ch. Items with at most one
// result sustain one item per cycle while rsp_ch is ready; an item with more holds the
// single result port until they drain; the next item is processed once the buffer is
// down to its final entry. Busy requests, stray bytes and unused codes cause no result.

module spi_flash_command_sequencer import sfcs_pkg::*; (
   input logic        clock,
   input logic        reset,
   sfcs_req_if.sink   req_ch,
   sfcs_rsp_if.source rsp_ch
);

   logic                           in_valid_ff, in_valid_in;
   req_item_type                   in_item_ff, in_item_in;
   rsp_item_type [MAX_RESULTS-1:0] buf_ff, buf_in;
   logic [1:0]                     cnt_ff, cnt_in;

   logic         req_fire;
   logic         rsp_fire;
   logic         process;
   step_out_type step;

   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign req_fire = req_ch.valid && req_ch.ready;
   // the buffer can take a new batch once it is empty or its last entry leaves now
   assign process  = in_valid_ff && ((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_fire));
   assign req_ch.ready = !in_valid_ff || process;

   sfcs_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (process),
      .item  (in_item_ff),
      .step  (step)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = req_ch.payload();
      end else if (process) begin
         in_valid_in = 1'b0;
      end

      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (process) begin
         buf_in = step.items;
         cnt_in = step.count;
      end else if (rsp_fire) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         buf_in[2] = '0;
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
      end
      in_item_ff <= in_item_in;
      buf_ff     <= buf_in;
   end

   assign rsp_ch.valid         = cnt_ff != 2'd0;
   assign rsp_ch.kind          = buf_ff[0].kind;
   assign rsp_ch.tx_byte       = buf_ff[0].tx_byte;
   assign rsp_ch.read_byte     = buf_ff[0].read_byte;
   assign rsp_ch.vendor_id     = buf_ff[0].vendor_id;
   assign rsp_ch.device_type   = buf_ff[0].device_type;
   assign rsp_ch.capacity_code = buf_ff[0].capacity_code;
   assign rsp_ch.last          = buf_ff[0].last;

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd1 |-> buf_ff[0].last)
      else $error("final buffered result not marked last");

   a_multi_not_last: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 || cnt_ff == 2'd3 |-> !buf_ff[0].last)
      else $error("result marked last with more results behind it");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending item lost or overwritten");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd1 && rsp_fire && !process |=> cnt_ff == 2'd0)
      else $error("result buffer count wrong after final transfer");

endmodule

[design/sfcs_engine.sv]
// sfcs_engine: command sequencing state machine, one item per fire strobe
// produces up to three results per item; depends on sfcs_pkg

module sfcs_engine import sfcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output step_out_type step
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  request_kind_ff, request_kind_in;
   logic [23:0] target_address_ff, target_address_in;
   logic [24:0] bytes_left_ff, bytes_left_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [7:0]  id_bytes_ff [2];
   logic [7:0]  id_bytes_in [2];

   logic [24:0]                    bytes_dec;
   rsp_item_type [MAX_RESULTS-1:0] items;
   logic [1:0]                     n;
   rsp_item_type                   id_report;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         request_kind_ff   <= '0;
         target_address_ff <= '0;
         bytes_left_ff     <= '0;
         byte_index_ff     <= '0;
         id_bytes_ff[0]    <= '0;
         id_bytes_ff[1]    <= '0;
      end else if (fire) begin
         phase_ff          <= phase_in;
         request_kind_ff   <= request_kind_in;
         target_address_ff <= target_address_in;
         bytes_left_ff     <= bytes_left_in;
         byte_index_ff     <= byte_index_in;
         id_bytes_ff[0]    <= id_bytes_in[0];
         id_bytes_ff[1]    <= id_bytes_in[1];
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      request_kind_in   = request_kind_ff;
      target_address_in = target_address_ff;
      bytes_left_in     = bytes_left_ff;
      byte_index_in     = byte_index_ff;
      id_bytes_in[0]    = id_bytes_ff[0];
      id_bytes_in[1]    = id_bytes_ff[1];
      items             = '0;
      n                 = 2'd0;
      bytes_dec         = bytes_left_ff - 25'd1;

      id_report               = kind_item(KIND_ID);
      id_report.vendor_id     = id_bytes_ff[0];
      id_report.device_type   = id_bytes_ff[1];
      id_report.capacity_code = item.rx_byte;

      unique case (item.operation)
         OP_READ_ID, OP_READ, OP_PROGRAM, OP_ERASE: begin
            // requests while busy are dropped
            if (phase_ff == PH_IDLE) begin
               request_kind_in   = item.operation[1:0];
               target_address_in = item.address;
               bytes_left_in     = (item.operation == OP_READ) ? item.length : '0;
               byte_index_in     = '0;
               n                 = 2'd1;
               if (item.operation[1]) begin
                  items[0] = xfer_item(CMD_WREN);
                  phase_in = PH_WREN;
               end else begin
                  items[0] = xfer_item(cmd_byte(item.operation[1:0]));
                  phase_in = PH_CMD;
               end
            end
         end
         OP_SPI_RX: begin
            unique case (phase_ff)
               PH_WREN: begin
                  items[0] = kind_item(KIND_RELEASE);
                  items[1] = xfer_item(cmd_byte(request_kind_ff));
                  n        = 2'd2;
                  phase_in = PH_CMD;
               end
               PH_CMD: begin
                  byte_index_in = '0;
                  n             = 2'd1;
                  if (request_kind_ff == 2'd0) begin
                     items[0] = xfer_item(DUMMY_BYTE);
                     phase_in = PH_IDDATA;
                  end else begin
                     items[0] = xfer_item(target_address_ff[23:16]);
                     phase_in = PH_ADDR;
                  end
               end
               PH_IDDATA: begin
                  if (byte_index_ff < 2'd2) begin
                     id_bytes_in[byte_index_ff[0]] = item.rx_byte;
                     byte_index_in = byte_index_ff + 2'd1;
                     items[0]      = xfer_item(DUMMY_BYTE);
                     n             = 2'd1;
                  end else begin
                     items[0]      = kind_item(KIND_RELEASE);
                     items[1]      = id_report;
                     items[2]      = kind_item(KIND_DONE);
                     n             = 2'd3;
                     phase_in      = PH_IDLE;
                     byte_index_in = '0;
                  end
               end
               PH_ADDR: begin
                  unique case (byte_index_ff)
                     2'd0: begin
                        byte_index_in = 2'd1;
                        items[0]      = xfer_item(target_address_ff[15:8]);
                        n             = 2'd1;
                     end
                     2'd1: begin
                        byte_index_in = 2'd2;
                        items[0]      = xfer_item(target_address_ff[7:0]);
                        n             = 2'd1;
                     end
                     default: begin
                        byte_index_in = '0;
                        priority if (request_kind_ff == 2'd1) begin
                           if (bytes_left_ff == '0) begin
                              items[0] = kind_item(KIND_RELEASE);
                              items[1] = kind_item(KIND_DONE);
                              n        = 2'd2;
                              phase_in = PH_IDLE;
                           end else begin
                              items[0] = xfer_item(DUMMY_BYTE);
                              n        = 2'd1;
                              phase_in = PH_RDATA;
                           end
                        end else if (request_kind_ff == 2'd2) begin
                           phase_in = PH_PWAIT;
                        end else begin
                           items[0] = kind_item(KIND_RELEASE);
                           items[1] = xfer_item(CMD_RDSR);
                           n        = 2'd2;
                           phase_in = PH_RDSR;
                        end
                     end
                  endcase
               end
               PH_RDATA: begin
                  bytes_left_in      = bytes_dec;
                  items[0]           = kind_item(KIND_DATA);
                  items[0].read_byte = item.rx_byte;
                  if (bytes_dec == '0) begin
                     items[1] = kind_item(KIND_RELEASE);
                     items[2] = kind_item(KIND_DONE);
                     n        = 2'd3;
                     phase_in = PH_IDLE;
                  end else begin
                     items[1] = xfer_item(DUMMY_BYTE);
                     n        = 2'd2;
                  end
               end
               PH_PBYTE: begin
                  phase_in = PH_PWAIT;
               end
               PH_PLAST: begin
                  items[0] = kind_item(KIND_RELEASE);
                  items[1] = kind_item(KIND_DONE);
                  n        = 2'd2;
                  phase_in = PH_IDLE;
               end
               PH_RDSR: begin
                  items[0] = xfer_item(DUMMY_BYTE);
                  n        = 2'd1;
                  phase_in = PH_POLL;
               end
               PH_POLL: begin
                  // keep polling while the busy bit is set
                  if (item.rx_byte[0]) begin
                     items[0] = xfer_item(DUMMY_BYTE);
                     n        = 2'd1;
                  end else begin
                     items[0] = kind_item(KIND_RELEASE);
                     items[1] = kind_item(KIND_DONE);
                     n        = 2'd2;
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  // idle or waiting for program data: stray byte
               end
            endcase
         end
         OP_PROG_DATA: begin
            if (phase_ff == PH_PWAIT) begin
               items[0] = xfer_item(item.data_byte);
               n        = 2'd1;
               phase_in = item.last_data ? PH_PLAST : PH_PBYTE;
            end
         end
         default: begin
         end
      endcase

      unique case (n)
         2'd1:    items[0].last = 1'b1;
         2'd2:    items[1].last = 1'b1;
         2'd3:    items[2].last = 1'b1;
         default: begin
         end
      endcase

      step.count = n;
      step.items = items;
   end

   a_idle_index_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> byte_index_ff == 2'd0)
      else $error("byte index not cleared while idle");

   a_rdata_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RDATA |-> bytes_left_ff != '0)
      else $error("read data phase with no bytes left");

   a_request_one_result: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_IDLE && item.operation[2] == 1'b0 |-> step.count == 2'd1)
      else $error("accepted request did not issue exactly one transfer");

   a_leave_idle_on_request: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_IDLE && item.operation[2] == 1'b0 |=> phase_ff != PH_IDLE)
      else $error("request accepted but sequencer stayed idle");

endmodule
